@@ rtl/sbb_pkg.sv @@
package sbb_pkg;

   // Fixed geometry of the row pass
   localparam int CHANNEL_BITS  = 24;
   localparam int NUM_CHANNELS  = 4;
   localparam int HISTORY_DEPTH = 64;
   localparam int SLOT_BITS     = $clog2(HISTORY_DEPTH);
   localparam int MAX_RADIUS    = 31;
   localparam int RADIUS_BITS   = 5;
   localparam int RADIUS_CAP    = (MAX_RADIUS < (HISTORY_DEPTH - 1) / 2) ?
                                  MAX_RADIUS : (HISTORY_DEPTH - 1) / 2;
   localparam int POS_MAX       = HISTORY_DEPTH - 1;

   // Register widths
   localparam int MODE_BITS      = 2;
   localparam int SCALE_BITS     = 17;
   localparam int WEIGHT_BITS    = 16;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 17;

   // Arithmetic widths
   localparam int FRAC_SHIFT = 16;
   localparam int SUM_BITS   = CHANNEL_BITS + $clog2(2 * RADIUS_CAP + 1);
   localparam int ACC_BITS   = CHANNEL_BITS + 18;
   localparam int PROD_BITS  = ACC_BITS + SCALE_BITS;
   localparam logic [CHANNEL_BITS-1:0] CH_MAX = {1'b0, {(CHANNEL_BITS - 1){1'b1}}};

   // Mode register codes
   localparam logic [MODE_BITS-1:0] MODE_BOX    = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_FRAC   = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_BYPASS = 2'd2;

   // Register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MODE        = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BOX_RADIUS  = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BOX_SCALE   = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAC_WEIGHT = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAC_SCALE  = 3'd4;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   typedef logic signed [CHANNEL_BITS-1:0] chan_type;
   typedef logic [NUM_CHANNELS-1:0][CHANNEL_BITS-1:0] pix_type;
   typedef logic [SLOT_BITS-1:0] slot_type;

   typedef enum logic [1:0] {
      KIND_BOX,
      KIND_FRAC,
      KIND_PASS
   } kind_type;

   typedef struct packed {
      pix_type  pix;
      logic     row_end;
      slot_type pos;
      slot_type slot;
      kind_type kind;
   } job_type;

   typedef struct packed {
      logic [MODE_BITS-1:0]   mode;
      logic [RADIUS_BITS-1:0] box_radius;
      logic [SCALE_BITS-1:0]  box_scale;
      logic [WEIGHT_BITS-1:0] frac_weight;
      logic [SCALE_BITS-1:0]  frac_scale;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      mode:        MODE_BYPASS,
      box_radius:  '0,
      box_scale:   17'd65536,
      frac_weight: '0,
      frac_scale:  17'd65536
   };

   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_BOX_START,
      ST_BOX_READ,
      ST_BOX_DRAIN,
      ST_BOX_MUL,
      ST_BOX_EMIT,
      ST_FRAC_READ,
      ST_FRAC_DRAIN,
      ST_FRAC_ACC,
      ST_FRAC_MUL,
      ST_FRAC_EMIT,
      ST_PASS_EMIT
   } back_state_type;

endpackage

@@ rtl/sbb_if.sv @@
interface sbb_req_if;
   logic              valid;
   logic              ready;
   sbb_pkg::chan_type red_in;
   sbb_pkg::chan_type green_in;
   sbb_pkg::chan_type blue_in;
   sbb_pkg::chan_type alpha_in;
   logic              row_end_in;
   modport source (output valid, red_in, green_in, blue_in, alpha_in, row_end_in,
                   input ready);
   modport sink   (input valid, red_in, green_in, blue_in, alpha_in, row_end_in,
                   output ready);
endinterface

interface sbb_rsp_if;
   logic              valid;
   logic              ready;
   sbb_pkg::chan_type red_out;
   sbb_pkg::chan_type green_out;
   sbb_pkg::chan_type blue_out;
   sbb_pkg::chan_type alpha_out;
   logic              row_end_out;
   modport source (output valid, red_out, green_out, blue_out, alpha_out, row_end_out,
                   input ready);
   modport sink   (input valid, red_out, green_out, blue_out, alpha_out, row_end_out,
                   output ready);
endinterface

interface sbb_csr_if;
   logic                                 valid;
   logic                                 ready;
   logic [sbb_pkg::CSR_INDEX_BITS-1:0]   index;
   logic [sbb_pkg::CSR_DATA_BITS-1:0]    data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/sbb_front.sv @@
module sbb_front (
   input  logic                          clock,
   input  logic                          reset,
   sbb_req_if.sink                       req,
   input  logic [sbb_pkg::MODE_BITS-1:0] mode,
   input  sbb_pkg::q_stat_type           q_stat,
   output logic                          q_push,
   output sbb_pkg::job_type              q_data
);

   sbb_pkg::slot_type pos_ff, pos_in;
   sbb_pkg::slot_type slot_ff, slot_in;
   sbb_pkg::kind_type kind;
   logic              accept;

   assign req.ready = !q_stat.full;
   assign accept    = req.valid && !q_stat.full;
   assign q_push    = accept;

   // Classify by the current mode; mode three acts as bypass
   always_comb begin
      unique case (mode)
         sbb_pkg::MODE_BOX:  kind = sbb_pkg::KIND_BOX;
         sbb_pkg::MODE_FRAC: kind = sbb_pkg::KIND_FRAC;
         default:            kind = sbb_pkg::KIND_PASS;
      endcase
   end

   always_comb begin
      q_data.pix[0]  = req.red_in;
      q_data.pix[1]  = req.green_in;
      q_data.pix[2]  = req.blue_in;
      q_data.pix[3]  = req.alpha_in;
      q_data.row_end = req.row_end_in;
      q_data.pos     = pos_ff;
      q_data.slot    = slot_ff;
      q_data.kind    = kind;
   end

   always_comb begin
      pos_in  = pos_ff;
      slot_in = slot_ff;
      if (accept) begin
         slot_in = slot_ff + 1'b1;
         priority if (req.row_end_in) pos_in = '0;
         else if (pos_ff != sbb_pkg::SLOT_BITS'(sbb_pkg::POS_MAX)) pos_in = pos_ff + 1'b1;
         else pos_in = pos_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         slot_ff <= '0;
      end else begin
         pos_ff  <= pos_in;
         slot_ff <= slot_in;
      end
   end

endmodule

@@ rtl/sbb_queue.sv @@
module sbb_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  sbb_pkg::job_type    push_data,
   input  logic                pop,
   output sbb_pkg::job_type    pop_data,
   output sbb_pkg::q_stat_type stat
);

   sbb_pkg::job_type                 data_ff [sbb_pkg::QUEUE_DEPTH];
   logic [sbb_pkg::QPTR_BITS-1:0]    wr_ptr_ff;
   logic [sbb_pkg::QPTR_BITS-1:0]    rd_ptr_ff;
   logic [sbb_pkg::QCNT_BITS-1:0]    count_ff, count_in;

   assign pop_data   = data_ff[rd_ptr_ff];
   assign stat.full  = (count_ff == sbb_pkg::QCNT_BITS'(sbb_pkg::QUEUE_DEPTH));
   assign stat.empty = (count_ff == '0);

   always_comb begin
      count_in = count_ff;
      if (push && !pop) count_in = count_ff + 1'b1;
      else if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (push) data_ff[wr_ptr_ff] <= push_data;
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         // Wrap the pointers at the queue depth
         if (push) wr_ptr_ff <= (wr_ptr_ff == sbb_pkg::QPTR_BITS'(sbb_pkg::QUEUE_DEPTH - 1)) ?
                                '0 : wr_ptr_ff + 1'b1;
         if (pop)  rd_ptr_ff <= (rd_ptr_ff == sbb_pkg::QPTR_BITS'(sbb_pkg::QUEUE_DEPTH - 1)) ?
                                '0 : rd_ptr_ff + 1'b1;
         count_ff <= count_in;
      end
   end

endmodule

@@ rtl/sbb_back.sv @@
module sbb_back (
   input  logic                clock,
   input  logic                reset,
   input  sbb_pkg::cfg_type    cfg,
   input  sbb_pkg::job_type    q_data,
   input  sbb_pkg::q_stat_type q_stat,
   output logic                q_pop,
   sbb_rsp_if.source           rsp
);

   localparam int CB = sbb_pkg::CHANNEL_BITS;
   localparam int NC = sbb_pkg::NUM_CHANNELS;
   localparam int PB = sbb_pkg::PROD_BITS;
   localparam int SB = sbb_pkg::SUM_BITS;
   localparam int AB = sbb_pkg::ACC_BITS;
   localparam int RB = sbb_pkg::RADIUS_BITS;
   localparam int LB = sbb_pkg::SLOT_BITS;
   localparam logic [PB-1:0] BOX_ROUND  = PB'(1) << (sbb_pkg::FRAC_SHIFT - 1);
   localparam logic [PB-1:0] FRAC_ROUND = PB'(1) << (2 * sbb_pkg::FRAC_SHIFT - 1);

   sbb_pkg::back_state_type state_ff, state_in;
   sbb_pkg::job_type        job_ff;
   sbb_pkg::pix_type        hist_mem [sbb_pkg::HISTORY_DEPTH];
   sbb_pkg::pix_type        rd_data_ff;
   sbb_pkg::pix_type        tap_ff [3];
   sbb_pkg::pix_type        out_pix_ff, out_pix;
   logic                    out_last_ff, out_last;
   logic                    out_valid_ff;
   logic [RB-1:0]           c_ff, c_in;
   logic [LB-1:0]           j_ff, j_in;
   logic [1:0]              rd_j_ff;
   logic                    rd_valid_ff;
   logic                    rd_en;
   sbb_pkg::slot_type       rd_addr;
   logic signed [SB-1:0]    sum_ff [NC];
   logic signed [AB-1:0]    acc_ff [NC];
   logic [PB-1:0]           prod_ff [NC];
   logic                    sum_clr, acc_en, mul_en, out_load, out_free;
   logic [RB-1:0]           rad, stop;
   logic [7:0]              a_raw;
   sbb_pkg::slot_type       a_idx, box_addr, frac_addr;
   sbb_pkg::pix_type        box_pix, frac_pix;

   function automatic logic [CB-1:0] clamp_pos(input logic [PB-1:0] y);
      logic [CB-1:0] r;
      if (y > PB'(sbb_pkg::CH_MAX)) r = sbb_pkg::CH_MAX;
      else r = y[CB-1:0];
      return r;
   endfunction

   assign rad  = (cfg.box_radius > RB'(sbb_pkg::RADIUS_CAP)) ?
                 RB'(sbb_pkg::RADIUS_CAP) : cfg.box_radius;
   assign stop = job_ff.row_end ? '0 : rad;

   // Window tap a = c + j - r steps back, clamped to the row ends
   assign a_raw    = 8'(c_ff) + 8'(j_ff) - 8'(rad);
   assign a_idx    = a_raw[7] ? '0 :
                     (a_raw[6:0] > 7'(job_ff.pos)) ? job_ff.pos : a_raw[LB-1:0];
   assign box_addr = job_ff.slot - a_idx;
   assign frac_addr = job_ff.slot - LB'(2'd2 - j_ff[1:0]);

   always_comb begin
      for (int ch = 0; ch < NC; ch++) begin
         if (sum_ff[ch] <= 0 || cfg.box_scale == '0) box_pix[ch] = '0;
         else box_pix[ch] = clamp_pos(prod_ff[ch] >> sbb_pkg::FRAC_SHIFT);
         if (acc_ff[ch] <= 0 || cfg.frac_scale == '0) frac_pix[ch] = '0;
         else frac_pix[ch] = clamp_pos(prod_ff[ch] >> (2 * sbb_pkg::FRAC_SHIFT));
      end
   end

   assign out_free = !out_valid_ff || rsp.ready;

   always_comb begin
      state_in = state_ff;
      q_pop    = 1'b0;
      rd_en    = 1'b0;
      rd_addr  = box_addr;
      j_in     = j_ff;
      c_in     = c_ff;
      sum_clr  = 1'b0;
      acc_en   = 1'b0;
      mul_en   = 1'b0;
      out_load = 1'b0;
      out_pix  = job_ff.pix;
      out_last = job_ff.row_end;
      unique case (state_ff)
         sbb_pkg::ST_IDLE: begin
            if (!q_stat.empty) begin
               q_pop = 1'b1;
               j_in  = '0;
               unique case (q_data.kind)
                  sbb_pkg::KIND_BOX: begin
                     c_in     = rad;
                     state_in = sbb_pkg::ST_BOX_START;
                  end
                  sbb_pkg::KIND_FRAC: begin
                     priority if (q_data.pos == '0) state_in = sbb_pkg::ST_PASS_EMIT;
                     else if (q_data.pos >= LB'(2)) state_in = sbb_pkg::ST_FRAC_READ;
                     else if (q_data.row_end) state_in = sbb_pkg::ST_PASS_EMIT;
                     else state_in = sbb_pkg::ST_IDLE;
                  end
                  default: state_in = sbb_pkg::ST_PASS_EMIT;
               endcase
            end
         end
         sbb_pkg::ST_BOX_START: begin
            if (LB'(c_ff) > job_ff.pos) begin
               // Centre not yet in the row: skip it
               if (c_ff == stop) state_in = sbb_pkg::ST_IDLE;
               else c_in = c_ff - 1'b1;
            end else begin
               j_in     = '0;
               sum_clr  = 1'b1;
               state_in = sbb_pkg::ST_BOX_READ;
            end
         end
         sbb_pkg::ST_BOX_READ: begin
            rd_en = 1'b1;
            if (j_ff == {rad, 1'b0}) state_in = sbb_pkg::ST_BOX_DRAIN;
            else j_in = j_ff + 1'b1;
         end
         sbb_pkg::ST_BOX_DRAIN: state_in = sbb_pkg::ST_BOX_MUL;
         sbb_pkg::ST_BOX_MUL: begin
            mul_en   = 1'b1;
            state_in = sbb_pkg::ST_BOX_EMIT;
         end
         sbb_pkg::ST_BOX_EMIT: begin
            if (out_free) begin
               out_load = 1'b1;
               out_pix  = box_pix;
               out_last = job_ff.row_end && (c_ff == '0);
               if (c_ff == stop) state_in = sbb_pkg::ST_IDLE;
               else begin
                  c_in     = c_ff - 1'b1;
                  state_in = sbb_pkg::ST_BOX_START;
               end
            end
         end
         sbb_pkg::ST_FRAC_READ: begin
            rd_en   = 1'b1;
            rd_addr = frac_addr;
            if (j_ff == LB'(2)) state_in = sbb_pkg::ST_FRAC_DRAIN;
            else j_in = j_ff + 1'b1;
         end
         sbb_pkg::ST_FRAC_DRAIN: state_in = sbb_pkg::ST_FRAC_ACC;
         sbb_pkg::ST_FRAC_ACC: begin
            acc_en   = 1'b1;
            state_in = sbb_pkg::ST_FRAC_MUL;
         end
         sbb_pkg::ST_FRAC_MUL: begin
            mul_en   = 1'b1;
            state_in = sbb_pkg::ST_FRAC_EMIT;
         end
         sbb_pkg::ST_FRAC_EMIT: begin
            if (out_free) begin
               out_load = 1'b1;
               out_pix  = frac_pix;
               out_last = 1'b0;
               state_in = job_ff.row_end ? sbb_pkg::ST_PASS_EMIT : sbb_pkg::ST_IDLE;
            end
         end
         sbb_pkg::ST_PASS_EMIT: begin
            if (out_free) begin
               out_load = 1'b1;
               state_in = sbb_pkg::ST_IDLE;
            end
         end
         default: state_in = sbb_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= sbb_pkg::ST_IDLE;
      else state_ff <= state_in;
   end

   // History ring: written when a job is taken, read one tap a cycle
   always_ff @(posedge clock) begin
      if (q_pop) begin
         job_ff                <= q_data;
         hist_mem[q_data.slot] <= q_data.pix;
      end
      if (rd_en) rd_data_ff <= hist_mem[rd_addr];
      j_ff    <= j_in;
      c_ff    <= c_in;
      rd_j_ff <= j_ff[1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) rd_valid_ff <= 1'b0;
      else rd_valid_ff <= rd_en;
   end

   always_ff @(posedge clock) begin
      for (int ch = 0; ch < NC; ch++) begin
         if (sum_clr) sum_ff[ch] <= '0;
         else if (rd_valid_ff && (state_ff == sbb_pkg::ST_BOX_READ ||
                                  state_ff == sbb_pkg::ST_BOX_DRAIN))
            sum_ff[ch] <= sum_ff[ch] + $signed(rd_data_ff[ch]);
         if (acc_en)
            acc_ff[ch] <= $signed({tap_ff[0][ch][CB-1], tap_ff[0][ch]}) +
                          $signed({tap_ff[2][ch][CB-1], tap_ff[2][ch]}) *
                          $signed({1'b0, cfg.frac_weight}) +
                          $signed({tap_ff[1][ch], sbb_pkg::FRAC_SHIFT'(0)}) -
                          $signed({tap_ff[0][ch][CB-1], tap_ff[0][ch]}) +
                          $signed({tap_ff[0][ch][CB-1], tap_ff[0][ch]}) *
                          $signed({1'b0, cfg.frac_weight});
         if (mul_en) begin
            if (state_ff == sbb_pkg::ST_BOX_MUL)
               prod_ff[ch] <= PB'(sum_ff[ch][SB-2:0]) * PB'(cfg.box_scale) + BOX_ROUND;
            else
               prod_ff[ch] <= PB'(acc_ff[ch][AB-2:0]) * PB'(cfg.frac_scale) + FRAC_ROUND;
         end
      end
      if (rd_valid_ff && (state_ff == sbb_pkg::ST_FRAC_READ ||
                          state_ff == sbb_pkg::ST_FRAC_DRAIN))
         tap_ff[rd_j_ff] <= rd_data_ff;
   end

   // Output register: hold until taken
   always_ff @(posedge clock) begin
      if (out_load) begin
         out_pix_ff  <= out_pix;
         out_last_ff <= out_last;
      end
      if (reset) out_valid_ff <= 1'b0;
      else if (out_load) out_valid_ff <= 1'b1;
      else if (rsp.ready) out_valid_ff <= 1'b0;
   end

   assign rsp.valid       = out_valid_ff;
   assign rsp.red_out     = out_pix_ff[0];
   assign rsp.green_out   = out_pix_ff[1];
   assign rsp.blue_out    = out_pix_ff[2];
   assign rsp.alpha_out   = out_pix_ff[3];
   assign rsp.row_end_out = out_last_ff;

endmodule

@@ rtl/separable_box_blur_row_pass_top.sv @@
// Row pass of a separable RGBA box blur with clamped row ends.
// req_bus: one pixel per beat (four signed s7.16 channels) and row_end_in on
//   the last pixel of a row. rsp_bus: filtered pixels, row_end_out on the last.
// csr_bus: register writes (mode, box_radius, box_scale, frac_weight,
//   frac_scale by index 0..4); always ready, write only while the block is idle.
// A front stage tracks row position and history slot and pushes a job into a
// two-entry queue; the back end owns the 64-entry history RAM and runs one job
// at a time, reading one history tap per cycle.
// Per job: bypass passes the pixel through; fractional reads three taps,
// accumulates, multiplies and emits, and also passes a row-end pixel through;
// box reads the 2r+1 window taps serially for each centre already in the row,
// then multiplies and emits it; one output per pixel once r pixels are in, up
// to r+1 on the row end. The single RAM read port makes the window sum serial.
// Reset clears the queue, row position, output register and registers (mode
// bypass, radius 0, scales 1.0, weight 0); history needs no clearing.
// When the receiver stalls, the output register holds its beat, the back end
// waits, and the queue fills before req ready drops.
module separable_box_blur_row_pass_top (
   input logic       clock,
   input logic       reset,
   sbb_req_if.sink   req_bus,
   sbb_rsp_if.source rsp_bus,
   sbb_csr_if.sink   csr_bus
);

   sbb_pkg::cfg_type    cfg_ff;
   sbb_pkg::job_type    push_data;
   sbb_pkg::job_type    pop_data;
   sbb_pkg::q_stat_type q_stat;
   logic                q_push;
   logic                q_pop;

   // Register writes are always taken
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= sbb_pkg::CFG_RESET;
      end else if (csr_bus.valid) begin
         unique case (csr_bus.index)
            sbb_pkg::CSR_MODE:        cfg_ff.mode        <= csr_bus.data[sbb_pkg::MODE_BITS-1:0];
            sbb_pkg::CSR_BOX_RADIUS:  cfg_ff.box_radius  <= csr_bus.data[sbb_pkg::RADIUS_BITS-1:0];
            sbb_pkg::CSR_BOX_SCALE:   cfg_ff.box_scale   <= csr_bus.data[sbb_pkg::SCALE_BITS-1:0];
            sbb_pkg::CSR_FRAC_WEIGHT: cfg_ff.frac_weight <= csr_bus.data[sbb_pkg::WEIGHT_BITS-1:0];
            sbb_pkg::CSR_FRAC_SCALE:  cfg_ff.frac_scale  <= csr_bus.data[sbb_pkg::SCALE_BITS-1:0];
            default: ; // drop writes beyond the register list
         endcase
      end
   end

   // Front: accept, classify, track row position and history slot
   sbb_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req    (req_bus),
      .mode   (cfg_ff.mode),
      .q_stat (q_stat),
      .q_push (q_push),
      .q_data (push_data)
   );

   // Decouple front and back
   sbb_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (push_data),
      .pop       (q_pop),
      .pop_data  (pop_data),
      .stat      (q_stat)
   );

   // Back: history RAM, window sums, three-tap filter, output register
   sbb_back u_back (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg_ff),
      .q_data (pop_data),
      .q_stat (q_stat),
      .q_pop  (q_pop),
      .rsp    (rsp_bus)
   );

   // The front must never push into a full queue
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(q_push && q_stat.full))
      else $error("job queue overflow");

   // The back end must never pop an empty queue
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(q_pop && q_stat.empty))
      else $error("job queue underflow");

   // No result beat right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_bus.valid)
      else $error("result valid after reset");

endmodule

@@ test/sbb_tb_scoreboard.sv @@
`timescale 1ns / 1ps

class blur_row_scoreboard;
   typedef struct packed {
      logic signed [23:0] red;
      logic signed [23:0] green;
      logic signed [23:0] blue;
      logic signed [23:0] alpha;
      logic               row_end;
   } pixel_beat_type;

   // settings mirror
   logic [1:0]  mode;
   logic [4:0]  box_radius;
   logic [16:0] box_scale;
   logic [15:0] frac_weight;
   logic [16:0] frac_scale;

   longint         history [64][4];
   longint         row_head [4];
   int             row_pos;
   int             wr_slot;
   int             cur_slot;
   pixel_beat_type pending_pixels [$];
   int             error_count;

   function new();
      mode = 2; box_radius = 0; box_scale = 65536; frac_weight = 0; frac_scale = 65536;
      row_pos = 0; wr_slot = 0; cur_slot = 0; error_count = 0;
      foreach (history[i, c]) history[i][c] = 0;
      foreach (row_head[c]) row_head[c] = 0;
   endfunction

   function void write_reg(logic [2:0] idx, logic [16:0] val);
      case (idx)
         sbb_pkg::CSR_MODE:        mode = val[1:0];
         sbb_pkg::CSR_BOX_RADIUS:  box_radius = val[4:0];
         sbb_pkg::CSR_BOX_SCALE:   box_scale = val;
         sbb_pkg::CSR_FRAC_WEIGHT: frac_weight = val[15:0];
         sbb_pkg::CSR_FRAC_SCALE:  frac_scale = val;
         default: ;
      endcase
   endfunction

   // tap a steps back, clamped to the row start
   function longint tap(int a, int p, int ch);
      if (a >= p && p < 63) return row_head[ch];
      if (a > p) a = p;
      return history[(cur_slot + 64 - a) % 64][ch];
   endfunction

   function longint window_mean(longint sum);
      longint y;
      if (sum <= 0 || box_scale == 0) return 0;
      y = (sum * longint'(box_scale) + 32768) >>> 16;
      return (y > 8388607) ? 8388607 : y;
   endfunction

   function longint three_tap(longint l, longint c, longint r);
      longint acc;
      logic [63:0] u, hi, lo, y;
      acc = (l + r) * longint'(frac_weight) + c * 65536;
      if (acc <= 0 || frac_scale == 0) return 0;
      u = acc;
      hi = u >> 32;
      lo = u & 64'hFFFF_FFFF;
      y = hi * frac_scale + ((lo * frac_scale + 64'h8000_0000) >> 32);
      return (y > 8388607) ? 8388607 : y;
   endfunction

   function void push_pixel(longint v [4], bit last);
      pixel_beat_type b;
      b.red = v[0][23:0]; b.green = v[1][23:0];
      b.blue = v[2][23:0]; b.alpha = v[3][23:0];
      b.row_end = last;
      pending_pixels.push_back(b);
   endfunction

   function void note_pixel(pixel_beat_type px_in);
      longint px [4];
      longint v [4];
      longint sum;
      int p, r, stop, a;
      bit last;
      p = row_pos;
      last = px_in.row_end;
      px[0] = px_in.red; px[1] = px_in.green; px[2] = px_in.blue; px[3] = px_in.alpha;
      cur_slot = wr_slot;
      for (int ch = 0; ch < 4; ch++) history[cur_slot][ch] = px[ch];
      wr_slot = (wr_slot + 1) % 64;
      if (p == 0) row_head = px;
      if (mode == sbb_pkg::MODE_BOX) begin
         r = (box_radius > 31) ? 31 : box_radius;
         stop = last ? 0 : r;
         for (int c = r; c >= stop; c--) begin
            if (c > p) continue;
            for (int ch = 0; ch < 4; ch++) begin
               sum = 0;
               for (int k = -r; k <= r; k++) begin
                  a = c + k;
                  if (a < 0) a = 0;
                  sum += tap(a, p, ch);
               end
               v[ch] = window_mean(sum);
            end
            push_pixel(v, last && c == 0);
         end
      end else if (mode == sbb_pkg::MODE_FRAC) begin
         if (p == 0) push_pixel(px, last);
         else begin
            if (p >= 2) begin
               for (int ch = 0; ch < 4; ch++)
                  v[ch] = three_tap(tap(2, p, ch), tap(1, p, ch), tap(0, p, ch));
               push_pixel(v, 0);
            end
            if (last) push_pixel(px, 1);
         end
      end else push_pixel(px, last);
      if (last) row_pos = 0;
      else if (p < 63) row_pos = p + 1;
   endfunction

   function void report(string what, longint got, longint want);
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
      error_count++;
   endfunction

   function void check_pixel(pixel_beat_type got);
      pixel_beat_type want;
      if (pending_pixels.size() == 0) begin
         report("unexpected beat", longint'(got.red), 0);
         return;
      end
      want = pending_pixels.pop_front();
      if (got.red !== want.red) report("red", got.red, want.red);
      if (got.green !== want.green) report("green", got.green, want.green);
      if (got.blue !== want.blue) report("blue", got.blue, want.blue);
      if (got.alpha !== want.alpha) report("alpha", got.alpha, want.alpha);
      if (got.row_end !== want.row_end) report("row_end", got.row_end, want.row_end);
   endfunction
endclass

@@ test/tb_separable_box_blur_row_pass_top.sv @@
`timescale 1ns / 1ps

module tb_separable_box_blur_row_pass_top;

   logic clock;
   logic reset;
   longint cycle_count = 0;
   int    items_sent;

   sbb_req_if req_bus ();
   sbb_rsp_if rsp_bus ();
   sbb_csr_if csr_bus ();

   blur_row_scoreboard blur_sb;

   separable_box_blur_row_pass_top dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   // Watchdog: worst case is ~32 outputs per item, each a serial window read,
   // stretched by receiver stalls; the limit is well above that.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 10000000) begin
         $display("separable_box_blur_row_pass_top test failed");
         $finish;
      end
   end

   // Receiver: sample at the rising edge, change ready at the falling edge.
   // Stall pattern cycles through calm, light and heavy back-pressure.
   int stall_phase = 0;
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         blur_sb.check_pixel({rsp_bus.red_out, rsp_bus.green_out, rsp_bus.blue_out,
                              rsp_bus.alpha_out, rsp_bus.row_end_out});
   end
   always @(negedge clock) begin
      stall_phase <= stall_phase + 1;
      case ((stall_phase / 200) % 3)
         0: rsp_bus.ready <= 1'b1;
         1: rsp_bus.ready <= ($urandom_range(3) != 0);
         default: rsp_bus.ready <= ($urandom_range(3) == 0);
      endcase
   end

   // Write one register; block is idle, so drive and wait for the beat.
   task automatic write_reg(logic [2:0] idx, logic [16:0] val);
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= val;
      do @(posedge clock); while (!csr_bus.ready);
      blur_sb.write_reg(idx, val);
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   task automatic set_config(logic [1:0] m, logic [4:0] r, logic [16:0] bs,
                             logic [15:0] fw, logic [16:0] fs);
      write_reg(sbb_pkg::CSR_MODE, 17'(m));
      write_reg(sbb_pkg::CSR_BOX_RADIUS, 17'(r));
      write_reg(sbb_pkg::CSR_BOX_SCALE, bs);
      write_reg(sbb_pkg::CSR_FRAC_WEIGHT, 17'(fw));
      write_reg(sbb_pkg::CSR_FRAC_SCALE, fs);
   endtask

   // Drain everything, then let the back end settle before a register write.
   task automatic wait_idle();
      int guard;
      guard = 0;
      while (blur_sb.pending_pixels.size() != 0 && guard < 500000) begin
         @(posedge clock);
         guard++;
      end
      repeat (80) @(posedge clock);
   endtask

   // Send one pixel beat; hold valid across back-to-back beats of a burst
   // and drop it between bursts.
   int burst_left;
   task automatic send_pixel(logic [23:0] rd, logic [23:0] gr, logic [23:0] bl,
                             logic [23:0] al, logic last);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(4, 1);
         repeat (gap) @(negedge clock);
         burst_left = $urandom_range(12, 1);
      end
      req_bus.valid      <= 1'b1;
      req_bus.red_in     <= rd;
      req_bus.green_in   <= gr;
      req_bus.blue_in    <= bl;
      req_bus.alpha_in   <= al;
      req_bus.row_end_in <= last;
      do @(posedge clock); while (!req_bus.ready);
      blur_sb.note_pixel({rd, gr, bl, al, last});
      items_sent++;
      burst_left--;
      @(negedge clock);
      if (burst_left == 0) req_bus.valid <= 1'b0;
   endtask

   task automatic idle_req();
      if (burst_left != 0) req_bus.valid <= 1'b0;
      burst_left = 0;
   endtask

   function automatic logic [23:0] rand_chan();
      case ($urandom_range(5))
         0: return 24'h800000;
         1: return 24'h7FFFFF;
         2: return 24'h000000;
         3: return 24'($urandom_range(24'h0FFFFF));
         default: return 24'($urandom);
      endcase
   endfunction

   // Random row of mostly short, sometimes long lengths.
   task automatic send_row(int len);
      for (int i = 0; i < len; i++)
         send_pixel(rand_chan(), rand_chan(), rand_chan(), rand_chan(), i == len - 1);
      idle_req();
   endtask

   int row_len;
   int r;

   initial begin
      blur_sb = new();
      items_sent = 0;
      burst_left = 0;
      reset = 1'b1;
      req_bus.valid = 0; req_bus.red_in = 0; req_bus.green_in = 0;
      req_bus.blue_in = 0; req_bus.alpha_in = 0; req_bus.row_end_in = 0;
      csr_bus.valid = 0; csr_bus.index = sbb_pkg::CSR_MODE; csr_bus.data = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: bypass at reset settings, extremes, one-pixel row.
      send_pixel(24'h7FFFFF, 24'h800000, 24'h000000, 24'hFFFFFF, 0);
      send_pixel(24'h800000, 24'h7FFFFF, 24'hFFFFFF, 24'h000000, 1);
      send_pixel(24'h123456, 24'hABCDEF, 24'h010000, 24'h800001, 1);
      idle_req();
      wait_idle();

      // Box r=1 and r=31 (zero scale), row shorter than r+1, saturating sums.
      set_config(sbb_pkg::MODE_BOX, 5'd1, 17'd21845, 16'd0, 17'd65536);
      send_pixel(24'h7FFFFF, 24'h7FFFFF, 24'h800000, 24'h010000, 0);
      send_pixel(24'h7FFFFF, 24'h000000, 24'h800000, 24'h020000, 0);
      send_pixel(24'h7FFFFF, 24'h7FFFFF, 24'h800000, 24'h030000, 1);
      send_pixel(24'h050000, 24'hFF0000, 24'h7FFFFF, 24'h000001, 1);
      idle_req();
      wait_idle();
      set_config(sbb_pkg::MODE_BOX, 5'd31, 17'd0, 16'd0, 17'd65536);
      send_row(3);
      wait_idle();

      // Fractional with max weight and extreme scales; 1-, 2- and 4-pixel rows.
      set_config(sbb_pkg::MODE_FRAC, 5'd31, 17'd131071, 16'd65535, 17'd21846);
      send_row(1);
      send_row(2);
      send_row(4);
      wait_idle();
      set_config(2'd3, 5'd0, 17'd1, 16'd0, 17'd0);
      send_row(2);
      wait_idle();

      // Random phases: mostly well-formed rows, a few long ones past history.
      while (items_sent < 280) begin
         case ($urandom_range(3))
            0: begin
               r = $urandom_range(31);
               if ($urandom_range(3) == 0) r = $urandom_range(3);
               set_config(sbb_pkg::MODE_BOX, 5'(r), 17'(65536 / (2 * r + 1)),
                          16'($urandom), 17'($urandom));
            end
            1: set_config(sbb_pkg::MODE_FRAC, 5'($urandom), 17'($urandom_range(131071)),
                          16'($urandom_range(65535)), 17'($urandom_range(65536, 21846)));
            2: set_config(sbb_pkg::MODE_BOX, 5'($urandom_range(6)),
                          17'($urandom_range(131071)), 16'($urandom), 17'($urandom));
            default: set_config(2'($urandom_range(3)), 5'($urandom), 17'($urandom),
                                16'($urandom), 17'($urandom));
         endcase
         for (int k = 0; k < 3; k++) begin
            row_len = ($urandom_range(7) == 0) ? $urandom_range(80, 40)
                                              : $urandom_range(12, 1);
            send_row(row_len);
         end
         wait_idle();
      end

      wait_idle();
      if (blur_sb.pending_pixels.size() != 0)
         blur_sb.report("missing beats", blur_sb.pending_pixels.size(), 0);
      if (blur_sb.error_count == 0)
         $display("separable_box_blur_row_pass_top test passed");
      else
         $display("separable_box_blur_row_pass_top test failed");
      $finish;
   end
endmodule
